>>> rtl/lexical_path_cleaner_macros.svh
// Assertion macros for the lexical path cleaner checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LEXICAL_PATH_CLEANER_MACROS_SVH
`define LEXICAL_PATH_CLEANER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexical_path_cleaner: check failed");

// Next-cycle implication, disabled while reset is high.
`define LPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexical_path_cleaner: check failed");

`endif

>>> rtl/lpc_pkg.sv
// Package for the lexical path cleaner: sizes, codes and beat types.
// Used by the top level and by its port checker; depends on nothing.
package lpc_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int LEN_W        = 13;
   localparam int IDX_W        = 12;
   localparam int NUM_BANKS    = 4;
   localparam int BANK_W       = 2;
   localparam int BANK_ROWS    = BUFFER_BYTES / NUM_BANKS;
   localparam int ROW_W        = IDX_W - BANK_W;
   localparam int STACK_SLOTS  = BUFFER_BYTES / 2;
   localparam int SP_W         = $clog2(STACK_SLOTS);
   localparam int DEPTH_W      = SP_W + 1;
   localparam int CNT_W        = 3;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [1:0] {
      ELEM_NONE,
      ELEM_DOT,
      ELEM_DOTDOT,
      ELEM_REAL
   } lpc_elem_type;

   typedef struct packed {
      logic             req_type;
      logic [7:0]       path_byte;
      logic [IDX_W-1:0] read_index;
   } lpc_req_type;

   typedef struct packed {
      logic             path_done;
      logic [LEN_W-1:0] clean_length;
      logic             overflow;
      logic [7:0]       read_data;
   } lpc_rsp_type;

   // Running result of the byte writes made by one beat.
   typedef struct packed {
      logic [LEN_W-1:0]            len;
      logic [LEN_W-1:0]            base;
      logic [CNT_W-1:0]            cnt;
      logic [NUM_BANKS-1:0][7:0]   bytes;
      logic                        ovf;
   } lpc_wr_type;

endpackage

>>> rtl/lexical_path_cleaner.sv
// Top level of the lexical path cleaner: streaming path cleaner with a banked
// output store and an element-start stack memory. Depends on lpc_pkg.
//
// The block takes one request beat per cycle unless responses stall and returns
// exactly one response beat for each, in order. A push beat carries one
// path byte; a zero byte ends the path and the next push starts a new one.
// Repeated slashes collapse, "." elements vanish, ".." removes the element
// before it, a leading ".." of a rooted path is dropped and a leading ".." of a
// relative path is kept, and an empty result reads as ".". A read beat returns
// the cleaned byte at read_index, or zero past the current length, together
// with path_done (high when no path is in progress), the current length and
// the overflow flag. Bytes beyond 4096 and element starts beyond 2048 are
// dropped and flag overflow. Sustained rate is one beat per cycle: the store
// is four byte-wide banks, so the up to four bytes that one push can emit land
// in one write cycle, and the top of the element stack is held in a register
// that the stack memory refreshes on every beat, with the pushed value
// forwarded when it lands on the address being read. Neither memory needs a
// clearing pass after reset, so the block accepts beats from the first cycle
// after reset. Backpressure on the response side holds the single response
// register and stalls the request side in the same cycle.
module lexical_path_cleaner (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpc_pkg::lpc_req_type req_beat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpc_pkg::lpc_rsp_type rsp_beat
);

   // Appends one byte to the beat's write group unless the store is full.
   function automatic lpc_pkg::lpc_wr_type put_byte(lpc_pkg::lpc_wr_type w,
                                                    logic [7:0] c);
      lpc_pkg::lpc_wr_type r;
      r = w;
      if (w.len < lpc_pkg::LEN_W'(lpc_pkg::BUFFER_BYTES)) begin
         if (w.cnt == '0) begin
            r.base = w.len;
         end
         r.bytes[w.cnt[lpc_pkg::BANK_W-1:0]] = c;
         r.cnt = w.cnt + lpc_pkg::CNT_W'(1);
         r.len = w.len + lpc_pkg::LEN_W'(1);
      end else begin
         r.ovf = 1'b1;
      end
      return r;
   endfunction

   // Path state.
   logic [lpc_pkg::LEN_W-1:0]   len_ff;
   logic                        ovf_ff;
   logic                        rooted_ff, rooted_in;
   lpc_pkg::lpc_elem_type       cls_ff, cls_in;
   logic [lpc_pkg::LEN_W-1:0]   begin_ff, begin_in;
   logic [lpc_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic                        first_ff, first_in;
   lpc_pkg::lpc_wr_type         wr_in;
   logic                        done_in;

   // Element-start stack: memory plus registered top entry.
   logic [lpc_pkg::LEN_W-1:0]   stack_mem [lpc_pkg::STACK_SLOTS];
   logic [lpc_pkg::LEN_W-1:0]   tos_ff;
   logic                        push_en;
   logic [lpc_pkg::LEN_W-1:0]   push_data;
   logic [lpc_pkg::SP_W-1:0]    push_addr;
   logic [lpc_pkg::DEPTH_W-1:0] depth_m1;
   logic [lpc_pkg::SP_W-1:0]    stack_raddr;

   // Banked output store.
   logic [7:0]                  bank_mem   [lpc_pkg::NUM_BANKS][lpc_pkg::BANK_ROWS];
   logic [7:0]                  bank_rd_ff [lpc_pkg::NUM_BANKS];
   logic                        bank_we    [lpc_pkg::NUM_BANKS];
   logic [lpc_pkg::ROW_W-1:0]   bank_row   [lpc_pkg::NUM_BANKS];
   logic [7:0]                  bank_wdata [lpc_pkg::NUM_BANKS];
   logic [lpc_pkg::ROW_W-1:0]   rd_row;

   // Response register.
   logic                        p1_valid_ff;
   logic                        p1_done_ff;
   logic [lpc_pkg::LEN_W-1:0]   p1_len_ff;
   logic                        p1_ovf_ff;
   logic                        p1_hit_ff;
   logic [lpc_pkg::BANK_W-1:0]  p1_sel_ff;

   // Per-beat decode temporaries.
   logic                        accept;
   logic                        is_push;
   logic                        consumed;
   logic                        open_elem;
   logic [1:0]                  dot_count;
   logic                        put_char;
   logic [7:0]                  c;
   logic [lpc_pkg::BANK_W-1:0]  bank_k;
   logic [lpc_pkg::LEN_W-1:0]   bank_addr;

   assign req_stall = p1_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_push   = (req_beat.req_type == lpc_pkg::REQ_PUSH);
   assign c         = req_beat.path_byte;

   // Next path state for the beat on the request port. The order of steps
   // follows the cleaning rules: path start, then close or extend an element.
   always_comb begin
      wr_in       = '0;
      wr_in.len   = len_ff;
      wr_in.base  = len_ff;
      wr_in.ovf   = ovf_ff;
      rooted_in   = rooted_ff;
      cls_in      = cls_ff;
      begin_in    = begin_ff;
      depth_in    = depth_ff;
      first_in    = first_ff;
      done_in     = 1'b0;
      push_en     = 1'b0;
      push_data   = begin_ff;
      push_addr   = depth_ff[lpc_pkg::SP_W-1:0];
      consumed    = 1'b0;
      open_elem   = 1'b0;
      dot_count   = 2'd0;
      put_char    = 1'b0;

      if (!is_push) begin
         done_in = first_ff;
      end else begin
         if (first_ff) begin
            wr_in.len  = '0;
            wr_in.base = '0;
            wr_in.ovf  = 1'b0;
            depth_in   = '0;
            cls_in     = lpc_pkg::ELEM_NONE;
            begin_in   = '0;
            rooted_in  = 1'b0;
            first_in   = 1'b0;
            if (c == lpc_pkg::CH_SLASH) begin
               rooted_in = 1'b1;
               wr_in     = put_byte(wr_in, lpc_pkg::CH_SLASH);
               consumed  = 1'b1;
            end
         end

         if (consumed) begin
            // The root slash is all this beat does.
         end else if (c == lpc_pkg::CH_END || c == lpc_pkg::CH_SLASH) begin
            // Close the open element; only ".." has an effect.
            if (cls_in == lpc_pkg::ELEM_DOTDOT) begin
               if (depth_in != '0) begin
                  depth_in  = depth_in - lpc_pkg::DEPTH_W'(1);
                  wr_in.len = tos_ff;
               end else if (!rooted_in) begin
                  if (wr_in.len != '0) begin
                     wr_in = put_byte(wr_in, lpc_pkg::CH_SLASH);
                  end
                  wr_in = put_byte(wr_in, lpc_pkg::CH_DOT);
                  wr_in = put_byte(wr_in, lpc_pkg::CH_DOT);
               end
            end
            cls_in = lpc_pkg::ELEM_NONE;
            if (c == lpc_pkg::CH_END) begin
               if (wr_in.len == '0) begin
                  wr_in = put_byte(wr_in, lpc_pkg::CH_DOT);
               end
               first_in = 1'b1;
               done_in  = 1'b1;
            end
         end else begin
            unique case (cls_in)
               lpc_pkg::ELEM_NONE: begin
                  begin_in = wr_in.len;
                  if (c == lpc_pkg::CH_DOT) begin
                     cls_in = lpc_pkg::ELEM_DOT;
                  end else begin
                     open_elem = 1'b1;
                  end
               end
               lpc_pkg::ELEM_DOT: begin
                  if (c == lpc_pkg::CH_DOT) begin
                     cls_in = lpc_pkg::ELEM_DOTDOT;
                  end else begin
                     open_elem = 1'b1;
                     dot_count = 2'd1;
                  end
               end
               lpc_pkg::ELEM_DOTDOT: begin
                  open_elem = 1'b1;
                  dot_count = 2'd2;
               end
               default: begin
                  put_char = 1'b1;
               end
            endcase

            if (open_elem) begin
               if (depth_in < lpc_pkg::DEPTH_W'(lpc_pkg::STACK_SLOTS)) begin
                  push_en   = 1'b1;
                  push_data = begin_in;
                  push_addr = depth_in[lpc_pkg::SP_W-1:0];
                  depth_in  = depth_in + lpc_pkg::DEPTH_W'(1);
               end else begin
                  wr_in.ovf = 1'b1;
               end
               if (wr_in.len != lpc_pkg::LEN_W'(rooted_in)) begin
                  wr_in = put_byte(wr_in, lpc_pkg::CH_SLASH);
               end
               if (dot_count != 2'd0) begin
                  wr_in = put_byte(wr_in, lpc_pkg::CH_DOT);
               end
               if (dot_count == 2'd2) begin
                  wr_in = put_byte(wr_in, lpc_pkg::CH_DOT);
               end
               cls_in   = lpc_pkg::ELEM_REAL;
               put_char = 1'b1;
            end
            if (put_char) begin
               wr_in = put_byte(wr_in, c);
            end
         end
      end
   end

   // Spread the beat's consecutive bytes over the banks: byte k of the group
   // lands in bank (base + k) mod 4.
   always_comb begin
      for (int b = 0; b < lpc_pkg::NUM_BANKS; b++) begin
         bank_k        = lpc_pkg::BANK_W'(b) - wr_in.base[lpc_pkg::BANK_W-1:0];
         bank_addr     = wr_in.base + lpc_pkg::LEN_W'(bank_k);
         bank_we[b]    = accept && ({1'b0, bank_k} < wr_in.cnt);
         bank_row[b]   = bank_addr[lpc_pkg::IDX_W-1:lpc_pkg::BANK_W];
         bank_wdata[b] = wr_in.bytes[bank_k];
      end
   end

   assign rd_row = req_beat.read_index[lpc_pkg::IDX_W-1:lpc_pkg::BANK_W];

   for (genvar gb = 0; gb < lpc_pkg::NUM_BANKS; gb++) begin : gen_bank
      always_ff @(posedge clock) begin
         if (bank_we[gb]) begin
            bank_mem[gb][bank_row[gb]] <= bank_wdata[gb];
         end
         if (accept && !is_push) begin
            bank_rd_ff[gb] <= bank_mem[gb][rd_row];
         end
      end
   end

   // The stack memory is read at the new top on every beat, so tos_ff always
   // holds the entry that a following ".." pops.
   assign depth_m1    = depth_in - lpc_pkg::DEPTH_W'(1);
   assign stack_raddr = depth_m1[lpc_pkg::SP_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         if (push_en) begin
            stack_mem[push_addr] <= push_data;
         end
         if (push_en && push_addr == stack_raddr) begin
            tos_ff <= push_data;
         end else begin
            tos_ff <= stack_mem[stack_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         rooted_ff <= 1'b0;
         cls_ff    <= lpc_pkg::ELEM_NONE;
         begin_ff  <= '0;
         depth_ff  <= '0;
         first_ff  <= 1'b1;
      end else if (accept) begin
         len_ff    <= wr_in.len;
         ovf_ff    <= wr_in.ovf;
         rooted_ff <= rooted_in;
         cls_ff    <= cls_in;
         begin_ff  <= begin_in;
         depth_ff  <= depth_in;
         first_ff  <= first_in;
      end
   end

   // Response register: holds while the response side stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (accept) begin
         p1_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         p1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_done_ff <= done_in;
         p1_len_ff  <= wr_in.len;
         p1_ovf_ff  <= wr_in.ovf;
         p1_hit_ff  <= !is_push &&
                       (lpc_pkg::LEN_W'(req_beat.read_index) < len_ff);
         p1_sel_ff  <= req_beat.read_index[lpc_pkg::BANK_W-1:0];
      end
   end

   assign rsp_valid              = p1_valid_ff;
   assign rsp_beat.path_done     = p1_done_ff;
   assign rsp_beat.clean_length  = p1_len_ff;
   assign rsp_beat.overflow      = p1_ovf_ff;
   assign rsp_beat.read_data     = p1_hit_ff ? bank_rd_ff[p1_sel_ff] : 8'h00;

endmodule

>>> rtl/lpc_checker.sv
// Port checker for the lexical path cleaner, bound to the top level.
// Depends on lpc_pkg and lexical_path_cleaner_macros.svh.
`include "lexical_path_cleaner_macros.svh"

module lpc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input lpc_pkg::lpc_req_type req_beat,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lpc_pkg::lpc_rsp_type rsp_beat
);

   logic                      req_acc;
   logic                      push_end;
   logic                      push_more;
   logic                      read_acc;
   logic                      end_ok;
   logic                      read_hit;
   logic [lpc_pkg::IDX_W-1:0] last_index_ff;

   assign req_acc   = req_valid && !req_stall;
   assign push_end  = req_acc && req_beat.req_type == lpc_pkg::REQ_PUSH &&
                      req_beat.path_byte == lpc_pkg::CH_END;
   assign push_more = req_acc && req_beat.req_type == lpc_pkg::REQ_PUSH &&
                      req_beat.path_byte != lpc_pkg::CH_END;
   assign read_acc  = req_acc && req_beat.req_type == lpc_pkg::REQ_READ;
   assign end_ok    = rsp_valid && rsp_beat.path_done && rsp_beat.clean_length != '0;
   assign read_hit  = rsp_beat.read_data == 8'h00 ||
                      lpc_pkg::LEN_W'(last_index_ff) < rsp_beat.clean_length;

   // Index of the beat offered at the previous edge.
   always_ff @(posedge clock) begin
      last_index_ff <= req_beat.read_index;
   end

   // A stalled response beat stays valid and unchanged.
   `LPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // An ending byte yields a finished, non-empty path in the next beat.
   `LPC_ASSERT_NEXT(a_end_done, clock, reset, push_end, end_ok)

   // Any other pushed byte leaves the path in progress.
   `LPC_ASSERT_NEXT(a_push_open, clock, reset, push_more, rsp_valid && !rsp_beat.path_done)

   // A read returns data only from inside the cleaned path.
   `LPC_ASSERT_NEXT(a_read_range, clock, reset, read_acc, rsp_valid && read_hit)

endmodule

bind lexical_path_cleaner lpc_checker u_lpc_checker (.*);

>>> verif/lpc_result_checker.sv
`timescale 1ns / 100ps
// Response checker for the lexical path cleaner: watches both channels, keeps
// its own copy of the cleaning state and compares every response beat in order.
// Depends on lpc_pkg for the beat types, sizes and character codes.
module lpc_result_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  lpc_pkg::lpc_req_type req_beat,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lpc_pkg::lpc_rsp_type rsp_beat,
   output int                   fail_count,
   output int                   pending
);

   // Shadow of the cleaned path and of the element-start stack.
   logic [7:0]                clean_bytes [lpc_pkg::BUFFER_BYTES];
   logic [lpc_pkg::LEN_W-1:0] elem_starts [lpc_pkg::STACK_SLOTS];
   int                        cur_len;
   int                        stack_top;
   int                        pend_begin;
   bit                        rooted;
   bit                        path_open;
   bit                        ovf_flag;
   lpc_pkg::lpc_elem_type     pend_class;

   lpc_pkg::lpc_rsp_type      expected_rsp_q [$];
   int                        rsp_seen;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: response %0d: %s got 0x%0h, expected 0x%0h",
               $time, rsp_seen, what, got, want);
      fail_count++;
   endtask

   function automatic void emit_byte(input logic [7:0] c);
      if (cur_len < lpc_pkg::BUFFER_BYTES) begin
         clean_bytes[cur_len] = c;
         cur_len++;
      end else begin
         ovf_flag = 1'b1;
      end
   endfunction

   // A real element begins: remember where it starts so that a later ".." can
   // cut back to it, then add the separator unless this is the first element.
   function automatic void open_element();
      if (stack_top < lpc_pkg::STACK_SLOTS) begin
         elem_starts[stack_top] = pend_begin[lpc_pkg::LEN_W-1:0];
         stack_top++;
      end else begin
         ovf_flag = 1'b1;
      end
      if (cur_len != int'(rooted))
         emit_byte(lpc_pkg::CH_SLASH);
      pend_class = lpc_pkg::ELEM_REAL;
   endfunction

   function automatic void close_element();
      if (pend_class == lpc_pkg::ELEM_DOTDOT) begin
         if (stack_top > 0) begin
            stack_top--;
            cur_len = int'(elem_starts[stack_top]);
         end else if (!rooted) begin
            if (cur_len != 0)
               emit_byte(lpc_pkg::CH_SLASH);
            emit_byte(lpc_pkg::CH_DOT);
            emit_byte(lpc_pkg::CH_DOT);
         end
      end
      pend_class = lpc_pkg::ELEM_NONE;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      case (pend_class)
         lpc_pkg::ELEM_NONE: begin
            pend_begin = cur_len;
            if (c == lpc_pkg::CH_DOT) begin
               pend_class = lpc_pkg::ELEM_DOT;
            end else begin
               open_element();
               emit_byte(c);
            end
         end
         lpc_pkg::ELEM_DOT: begin
            if (c == lpc_pkg::CH_DOT) begin
               pend_class = lpc_pkg::ELEM_DOTDOT;
            end else begin
               open_element();
               emit_byte(lpc_pkg::CH_DOT);
               emit_byte(c);
            end
         end
         lpc_pkg::ELEM_DOTDOT: begin
            open_element();
            emit_byte(lpc_pkg::CH_DOT);
            emit_byte(lpc_pkg::CH_DOT);
            emit_byte(c);
         end
         default: emit_byte(c);
      endcase
   endfunction

   function automatic lpc_pkg::lpc_rsp_type predict_clean(input lpc_pkg::lpc_req_type b);
      lpc_pkg::lpc_rsp_type r;
      bit                   consumed;
      r        = '0;
      consumed = 1'b0;
      if (b.req_type == lpc_pkg::REQ_READ) begin
         if (int'(b.read_index) < cur_len)
            r.read_data = clean_bytes[b.read_index];
         r.path_done = !path_open;
      end else begin
         if (!path_open) begin
            cur_len    = 0;
            stack_top  = 0;
            pend_class = lpc_pkg::ELEM_NONE;
            pend_begin = 0;
            ovf_flag   = 1'b0;
            rooted     = 1'b0;
            path_open  = 1'b1;
            if (b.path_byte == lpc_pkg::CH_SLASH) begin
               rooted   = 1'b1;
               consumed = 1'b1;
               emit_byte(lpc_pkg::CH_SLASH);
            end
         end
         if (consumed) begin
            // The root slash has been written already.
         end else if (b.path_byte == lpc_pkg::CH_END) begin
            close_element();
            if (cur_len == 0)
               emit_byte(lpc_pkg::CH_DOT);
            path_open   = 1'b0;
            r.path_done = 1'b1;
         end else if (b.path_byte == lpc_pkg::CH_SLASH) begin
            close_element();
         end else begin
            take_char(b.path_byte);
         end
      end
      r.clean_length = cur_len[lpc_pkg::LEN_W-1:0];
      r.overflow     = ovf_flag;
      return r;
   endfunction

   // Predict before comparing, so the check holds for any response latency.
   always @(posedge clock) begin
      lpc_pkg::lpc_rsp_type want;
      if (reset) begin
         cur_len    = 0;
         stack_top  = 0;
         pend_begin = 0;
         rooted     = 1'b0;
         path_open  = 1'b0;
         ovf_flag   = 1'b0;
         pend_class = lpc_pkg::ELEM_NONE;
         fail_count = 0;
         rsp_seen   = 0;
         expected_rsp_q.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_clean(req_beat));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("beat with nothing expected", int'(rsp_beat), 0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_beat.path_done !== want.path_done)
                  report_mismatch("path_done", int'(rsp_beat.path_done),
                                  int'(want.path_done));
               if (rsp_beat.clean_length !== want.clean_length)
                  report_mismatch("clean_length", int'(rsp_beat.clean_length),
                                  int'(want.clean_length));
               if (rsp_beat.overflow !== want.overflow)
                  report_mismatch("overflow", int'(rsp_beat.overflow),
                                  int'(want.overflow));
               if (rsp_beat.read_data !== want.read_data)
                  report_mismatch("read_data", int'(rsp_beat.read_data),
                                  int'(want.read_data));
            end
            rsp_seen++;
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

>>> verif/tb_lexical_path_cleaner.sv
`timescale 1ns / 100ps
// Top of the lexical path cleaner testbench: clock, reset, stimulus and verdict.
// Depends on lpc_pkg, the lexical_path_cleaner block and lpc_result_checker.
module tb_lexical_path_cleaner;

   // Generous bound: the whole run is well under a thousand beats.
   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_PER_PHASE = 225;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lpc_pkg::lpc_req_type req_beat  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lpc_pkg::lpc_rsp_type rsp_beat;

   int fail_count;
   int pending;
   int send_idle_pct  = 28;
   int recv_stall_pct = 55;
   int beats_sent     = 0;
   int cycle_count    = 0;

   always #10 clock = ~clock;

   lexical_path_cleaner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   // The checker sits beside the block, predicts every response from the
   // accepted request beats and hands back its failure count.
   lpc_result_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // The receiver stalls at random; the rate changes with the phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lexical_path_cleaner verification failed");
         $finish;
      end
   end

   // Offers one beat and returns at the edge where it is accepted. Idle cycles
   // are inserted in front of the beat, never between a raise and a lower in
   // the same step, so back-to-back beats keep valid high throughout.
   task automatic send_beat(input lpc_pkg::lpc_req_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_push(input logic [7:0] c);
      lpc_pkg::lpc_req_type b;
      b.req_type   = lpc_pkg::REQ_PUSH;
      b.path_byte  = c;
      b.read_index = lpc_pkg::IDX_W'($urandom_range(0, 4095));
      send_beat(b);
   endtask

   task automatic send_read(input int idx);
      lpc_pkg::lpc_req_type b;
      b.req_type   = lpc_pkg::REQ_READ;
      b.path_byte  = 8'($urandom_range(0, 255));
      b.read_index = lpc_pkg::IDX_W'(idx);
      send_beat(b);
   endtask

   // Pushes the characters of a string, optionally followed by the end byte.
   task automatic send_text(input string s, input bit terminate);
      for (int i = 0; i < s.len(); i++)
         send_push(s[i]);
      if (terminate)
         send_push(lpc_pkg::CH_END);
   endtask

   // Holds the request side idle until every response has come back. The
   // pending count is looked at on the falling edge, well away from the
   // checker's update on the rising edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One path built from elements of the kinds that steer the cleaner: empty
   // elements, dots, dot-dots, names that only start or end with dots, plain
   // names and arbitrary bytes. Most paths end properly; some run on into the
   // next one, and reads are sprinkled in while a path is open and after it.
   task automatic send_random_path();
      int n_elem;
      int n_chars;
      n_elem = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0)
         send_push(lpc_pkg::CH_SLASH);
      for (int e = 0; e < n_elem; e++) begin
         n_chars = $urandom_range(1, 3);
         case ($urandom_range(0, 9))
            0: ;
            1: send_push(lpc_pkg::CH_DOT);
            2, 3: send_text("..", 1'b0);
            4: send_text("...", 1'b0);
            5: begin
               send_push(lpc_pkg::CH_DOT);
               send_push(8'($urandom_range(8'h61, 8'h7a)));
            end
            6: begin
               send_push(8'($urandom_range(8'h61, 8'h7a)));
               send_text("..", 1'b0);
            end
            7, 8: repeat (n_chars) send_push(8'($urandom_range(8'h61, 8'h7a)));
            default: repeat (n_chars) send_push(8'($urandom_range(1, 255)));
         endcase
         if (e < n_elem - 1 || $urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, 3) == 0 ? 2 : 1) send_push(lpc_pkg::CH_SLASH);
         if ($urandom_range(0, 7) == 0)
            send_read($urandom_range(0, 12));
      end
      if ($urandom_range(0, 9) != 0)
         send_push(lpc_pkg::CH_END);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0)
            send_read($urandom_range(0, 4095));
         else
            send_read($urandom_range(0, 24));
      end
   endtask

   // Random part of one phase: mostly well-formed paths, now and then a few
   // beats of pure noise, and once in a while a full drain of the responses.
   task automatic run_random(input int count);
      int stop_at;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) send_beat(lpc_pkg::lpc_req_type'($urandom));
         send_random_path();
         if ($urandom_range(0, 15) == 0)
            drain_results();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles now and then, receiver stalls often.
      send_idle_pct = 28;
      recv_stall_pct <= 55;

      // No path has started yet, so a read must report done with length zero.
      send_read(0);
      send_read(4095);
      // An empty path cleans to a single dot, and a lone slash stays a slash.
      send_text("", 1'b1);
      send_text("/", 1'b1);
      // Collapsed slashes, dropped dot, dot-dot eating the element before it.
      send_text("//a//./b/../c/", 1'b1);
      // A relative path keeps the dot-dots it cannot undo.
      send_text("../../x/..", 1'b1);
      // A rooted path drops a leading dot-dot.
      send_text("/../a", 1'b1);
      // Dots that turn into real names once more characters follow.
      send_text(".a/..b/.../c..", 1'b1);
      send_text("a/..", 1'b1);
      for (int i = 0; i < 14; i++)
         send_read(i);
      // Reads while a path is still open, and bytes with the top bits set.
      send_text("/ab", 1'b0);
      send_read(1);
      send_push(8'hFF);
      send_push(8'h80);
      send_push(8'h01);
      send_push(lpc_pkg::CH_END);
      send_read(3);
      drain_results();

      run_random(RANDOM_PER_PHASE);
      drain_results();

      // Phase two: the sender is the slow side.
      send_idle_pct = 55;
      recv_stall_pct <= 28;
      run_random(RANDOM_PER_PHASE);
      drain_results();

      // Phase three: full rate on both sides.
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      run_random(RANDOM_PER_PHASE);

      drain_results();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("lexical_path_cleaner verification clean");
      else
         $display("lexical_path_cleaner verification failed");
      $finish;
   end

endmodule
